FILE: rtl/bms_pkg.sv
// Shared constants, types and the neighbor vote function for the majority smoothing block.
package bms_pkg;

   localparam int PIXEL_W = 8;
   localparam int CFG_W = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int RESET_FRAME_WIDTH = 640;
   localparam int RESET_FRAME_HEIGHT = 480;
   localparam int MIN_FRAME_SIZE = 3;

   // Result queue depth: one word on show, one behind it, one still in the pipe.
   localparam int OUT_Q_DEPTH = 3;

   typedef struct packed {
      logic valid;
      logic emit;
      logic interior;
      logic last;
      logic fwd;
   } s1_ctrl_type;

   typedef struct packed {
      logic               last;
      logic [PIXEL_W-1:0] pixel;
   } rsp_entry_type;

   // Most frequent of the four neighbors; the first in up, down, left, right order wins ties.
   function automatic logic [PIXEL_W-1:0] majority_pick(input logic [PIXEL_W-1:0] up,
                                                        input logic [PIXEL_W-1:0] dn,
                                                        input logic [PIXEL_W-1:0] lt,
                                                        input logic [PIXEL_W-1:0] rt);
      logic [PIXEL_W-1:0] vals [4];
      logic [2:0]         n;
      logic [2:0]         best_n;
      logic [1:0]         best;
      vals[0] = up;
      vals[1] = dn;
      vals[2] = lt;
      vals[3] = rt;
      best = 2'd0;
      best_n = 3'd0;
      for (int i = 0; i < 4; i++) begin
         n = 3'd0;
         for (int j = 0; j < 4; j++) begin
            n = n + 3'(vals[i] == vals[j]);
         end
         if (n > best_n) begin
            best_n = n;
            best = 2'(i);
         end
      end
      return vals[best];
   endfunction

endpackage

FILE: rtl/bms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/boundary_majority_smoothing.sv
// Top level of the streaming 4-neighbor majority smoothing filter.
//
// Usage. Indexed 8-bit pixels of a frame enter in raster order on the req_ stream,
// one word per pixel. A word with req_tuser set is a pad: it carries no pixel and
// is dropped while the frame is still arriving. Once all pixels of the frame are in,
// every word (pad or not) only pushes out the remaining results. The smoothed frame
// leaves on the rsp_ stream in raster order, lagging the input by frame_width + 1
// words, so frame_width + 1 words must follow the last pixel; rsp_tlast marks the
// last pixel of the frame, after which the next word starts a new frame.
// The csr_ channel writes frame_width (index 0) and frame_height (index 1); sizes
// are clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT], and a size write restarts the frame.
// Throughput is one word per clock while the result side keeps up: the two line RAMs
// are read at the column of the incoming word and written back in the next cycle at the
// same column. The word that releases a result is registered into stage 1, which writes
// the result into a three-entry result queue shown on rsp_. The queue decouples the sides,
// so input keeps flowing while a result waits; a stalled receiver stops input once the
// queued results and the word in the pipe stage together number three.
// Reset (synchronous, active high) restores 640 x 480, clears the position counters,
// the window and the queue. Line RAM contents are not cleared; stale entries only
// feed border results, which pass through unchanged.
module boundary_majority_smoothing #(
   parameter int MAX_WIDTH = bms_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bms_pkg::MAX_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input stream.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bms_pkg::PIXEL_W-1:0]    req_tdata,   // [7:0] pixel_in
   input  logic                           req_tuser,   // [0] pad
   // Result stream.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bms_pkg::PIXEL_W-1:0]    rsp_tdata,   // [7:0] pixel_out
   output logic                           rsp_tlast,   // frame_last
   // Register write channel.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bms_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int WW = $clog2(MAX_WIDTH + 1);    // clamped width register
   localparam int HW = $clog2(MAX_HEIGHT + 1);   // clamped height register
   localparam int AW = $clog2(MAX_WIDTH);        // column counter and RAM address
   localparam int RW = $clog2(MAX_HEIGHT + 2);   // row counter, runs to height + 1
   localparam int CCW = WW + 1;
   localparam int RCW = RW + 1;
   localparam int QAW = $clog2(bms_pkg::OUT_Q_DEPTH);
   localparam int QCW = $clog2(bms_pkg::OUT_Q_DEPTH + 1);
   localparam int W_RST = (bms_pkg::RESET_FRAME_WIDTH > MAX_WIDTH) ?
                          MAX_WIDTH : bms_pkg::RESET_FRAME_WIDTH;
   localparam int H_RST = (bms_pkg::RESET_FRAME_HEIGHT > MAX_HEIGHT) ?
                          MAX_HEIGHT : bms_pkg::RESET_FRAME_HEIGHT;
   localparam int PW = bms_pkg::PIXEL_W;

   // Frame size, already clamped.
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;

   // Position of the next input word.
   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Stage 1: the word whose line RAM reads are returning this cycle.
   bms_pkg::s1_ctrl_type s1_ff, s1_in;
   logic [AW-1:0] s1_col_ff;
   logic [PW-1:0] s1_pix_ff;
   logic [PW-1:0] fwd_above_ff, fwd_two_above_ff;

   // Sliding window: up delayed one, center delayed one and two, down delayed one.
   logic [PW-1:0] win_up_ff, win_c1_ff, win_c2_ff, win_dn_ff;

   // Result queue.
   bms_pkg::rsp_entry_type q_ff [bms_pkg::OUT_Q_DEPTH];
   logic [QAW-1:0] q_wr_ff, q_wr_in, q_rd_ff, q_rd_in;
   logic [QCW-1:0] q_cnt_ff, q_cnt_in;

   logic          acc, take, tail, is_pad;
   logic          emit0, interior0, last0, col_inside;
   logic [CCW-1:0] col_plus;
   logic [RCW-1:0] row_ext, height_ext;
   logic          cfg_wr;

   logic [PW-1:0] ram_above_rd, ram_two_above_rd;
   logic [PW-1:0] mid, top, result;
   logic [2:0]    diff_cnt;
   logic          push, pop;

   // ---------------------------------------------------------------- configuration
   assign csr_ready = 1'b1;
   assign cfg_wr = csr_valid && csr_ready &&
                   (csr_index == bms_pkg::CSR_FRAME_WIDTH ||
                    csr_index == bms_pkg::CSR_FRAME_HEIGHT);

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bms_pkg::CSR_FRAME_WIDTH: begin
               if (32'(csr_wdata) < 32'(bms_pkg::MIN_FRAME_SIZE)) begin
                  width_in = WW'(bms_pkg::MIN_FRAME_SIZE);
               end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(csr_wdata);
               end
            end
            bms_pkg::CSR_FRAME_HEIGHT: begin
               if (32'(csr_wdata) < 32'(bms_pkg::MIN_FRAME_SIZE)) begin
                  height_in = HW'(bms_pkg::MIN_FRAME_SIZE);
               end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
                  height_in = HW'(MAX_HEIGHT);
               end else begin
                  height_in = HW'(csr_wdata);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 0
   assign req_tready = ({1'b0, q_cnt_ff} + (QCW + 1)'(s1_ff.valid)) <
                       (QCW + 1)'(bms_pkg::OUT_Q_DEPTH);
   assign acc = req_tvalid && req_tready;
   assign is_pad = req_tuser;

   assign row_ext = RCW'(row_ff);
   assign height_ext = RCW'(height_ff);
   assign tail = row_ext >= height_ext;
   // A pad before the frame is complete is dropped without a trace.
   assign take = acc && !(is_pad && !tail);

   assign col_plus = CCW'(col_ff) + CCW'(1);
   assign col_inside = col_plus <= CCW'(width_ff);

   assign emit0 = (row_ff >= RW'(2)) || (row_ff == RW'(1) && col_ff != AW'(0));
   assign interior0 = (col_ff >= AW'(2)) && col_inside && (row_ff >= RW'(2)) && !tail;
   assign last0 = (row_ext == height_ext + RCW'(1)) && (col_ff == AW'(0));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (last0) begin
            col_in = '0;
            row_in = '0;
         end else if (col_plus >= CCW'(width_ff)) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_plus[AW-1:0];
         end
      end
   end

   always_comb begin
      s1_in.valid = take;
      s1_in.emit = emit0;
      s1_in.interior = interior0;
      s1_in.last = last0;
      // The previous word writes back this same column only where a new frame starts behind it.
      s1_in.fwd = take && s1_ff.valid && (col_ff == s1_col_ff);
   end

   // ---------------------------------------------------------------- line RAMs
   bms_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_above (
      .clock   (clock),
      .wr_en   (s1_ff.valid),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (take),
      .rd_addr (col_ff),
      .rd_data (ram_above_rd)
   );

   bms_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_two_above (
      .clock   (clock),
      .wr_en   (s1_ff.valid),
      .wr_addr (s1_col_ff),
      .wr_data (mid),
      .rd_en   (take),
      .rd_addr (col_ff),
      .rd_data (ram_two_above_rd)
   );

   // ---------------------------------------------------------------- stage 1
   assign mid = s1_ff.fwd ? fwd_above_ff : ram_above_rd;
   assign top = s1_ff.fwd ? fwd_two_above_ff : ram_two_above_rd;

   // Neighbors disagreeing with the center pixel; right is the row-above read.
   assign diff_cnt = 3'(win_c1_ff != win_up_ff) + 3'(win_c1_ff != win_dn_ff) +
                     3'(win_c1_ff != win_c2_ff) + 3'(win_c1_ff != mid);

   always_comb begin
      result = win_c1_ff;
      if (s1_ff.interior && diff_cnt >= 3'd2) begin
         result = bms_pkg::majority_pick(win_up_ff, win_dn_ff, win_c2_ff, mid);
      end
   end

   // ---------------------------------------------------------------- result queue
   assign push = s1_ff.valid && s1_ff.emit;
   assign pop = rsp_tvalid && rsp_tready;

   always_comb begin
      q_wr_in = q_wr_ff;
      q_rd_in = q_rd_ff;
      q_cnt_in = q_cnt_ff;
      if (push) begin
         q_wr_in = (q_wr_ff == QAW'(bms_pkg::OUT_Q_DEPTH - 1)) ? '0 : q_wr_ff + QAW'(1);
      end
      if (pop) begin
         q_rd_in = (q_rd_ff == QAW'(bms_pkg::OUT_Q_DEPTH - 1)) ? '0 : q_rd_ff + QAW'(1);
      end
      if (push && !pop) begin
         q_cnt_in = q_cnt_ff + QCW'(1);
      end else if (pop && !push) begin
         q_cnt_in = q_cnt_ff - QCW'(1);
      end
   end

   assign rsp_tvalid = q_cnt_ff != '0;
   assign rsp_tdata = q_ff[q_rd_ff].pixel;
   assign rsp_tlast = q_ff[q_rd_ff].last;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WW'(W_RST);
         height_ff <= HW'(H_RST);
         col_ff <= '0;
         row_ff <= '0;
         s1_ff <= '0;
         win_up_ff <= '0;
         win_c1_ff <= '0;
         win_c2_ff <= '0;
         win_dn_ff <= '0;
         q_wr_ff <= '0;
         q_rd_ff <= '0;
         q_cnt_ff <= '0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         col_ff <= col_in;
         row_ff <= row_in;
         s1_ff <= s1_in;
         if (s1_ff.valid) begin
            win_up_ff <= top;
            win_c2_ff <= win_c1_ff;
            win_c1_ff <= mid;
            win_dn_ff <= s1_pix_ff;
         end
         q_wr_ff <= q_wr_in;
         q_rd_ff <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff <= col_ff;
      s1_pix_ff <= tail ? '0 : req_tdata;
      fwd_above_ff <= s1_pix_ff;
      fwd_two_above_ff <= mid;
      if (push) begin
         q_ff[q_wr_ff].pixel <= result;
         q_ff[q_wr_ff].last <= s1_ff.last;
      end
   end

endmodule

FILE: rtl/bms_chk.sv
// Port-level checker for the majority smoothing block, bound to its top level.
module bms_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [bms_pkg::PIXEL_W-1:0] rsp_tdata,
   input logic                        rsp_tlast
);

   // The result queue is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   // A result only appears once an input word taken earlier has passed stage 1 into the queue.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result appeared without an input word two cycles earlier");

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result payload changed while stalled");

endmodule

bind boundary_majority_smoothing bms_chk u_bms_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: dv/tb_top.sv
// Self-checking testbench for the streaming 4-neighbor majority smoothing filter.
module tb_top;

   localparam int PW = bms_pkg::PIXEL_W;
   localparam int CW = bms_pkg::CFG_W;
   localparam int COL_W = $clog2(bms_pkg::MAX_WIDTH_DEF);

   // Register indexes that the block does not decode; writes to them must be ignored.
   localparam logic [bms_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [bms_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   // Lets the pipe stage and the result queue empty after the last releasing word.
   localparam int SETTLE_CYCLES = 8;
   // Longest run of cycles without any handshake before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Counted words (frame pixels and tail words) for the random part of the run.
   localparam int RANDOM_WORDS = 1150;

   // Directed 3x3 frames, raster pixel k in byte k.
   // Center 255 sees up 1, down 1, left 2, right 2: a tie, so up wins.
   localparam logic [8:0][PW-1:0] TIE_FRAME =
      {8'd0, 8'd1, 8'd0, 8'd2, 8'd255, 8'd2, 8'd0, 8'd1, 8'd0};
   // Raster 7 0 7 / 255 9 255 / 7 255 7: center 9 sees up 0 and three 255s, so down wins.
   localparam logic [8:0][PW-1:0] DOWN_WINS_FRAME =
      {8'd7, 8'd255, 8'd7, 8'd255, 8'd9, 8'd255, 8'd7, 8'd0, 8'd7};

   // One input word as it waits in the driver queue.
   typedef struct packed {
      logic          pad;
      logic [PW-1:0] pixel;
   } pixel_word_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [PW-1:0]                     req_tdata = '0;   // [7:0] pixel_in
   logic                              req_tuser = 1'b0; // [0] pad
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [PW-1:0]                     rsp_tdata;        // [7:0] pixel_out
   logic                              rsp_tlast;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [bms_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [CW-1:0]                     csr_wdata = '0;

   // Idle percentages of the two sides; the stimulus changes them phase by phase.
   int unsigned send_idle_pct = 34;
   int unsigned recv_idle_pct = 54;

   pixel_word_type         word_queue[$];     // words not yet accepted by the block
   bms_pkg::rsp_entry_type smoothed_queue[$]; // smoothed pixels still to come out
   bms_pkg::rsp_entry_type oldest_smoothed;

   // Predictor state: sizes as written, two line stores, the 3x3 window taps and position.
   logic [CW-1:0] width_reg;
   logic [CW-1:0] height_reg;
   logic [PW-1:0] line_above [bms_pkg::MAX_WIDTH_DEF];
   logic [PW-1:0] line_two_above [bms_pkg::MAX_WIDTH_DEF];
   logic [PW-1:0] win_up, win_centre, win_left, win_down;
   int unsigned   col_pos, row_pos, emitted;

   // Bookkeeping for the verdict and the summary.
   int unsigned failures = 0;
   int unsigned results_checked = 0;
   int unsigned frames_done = 0;
   int unsigned csr_writes = 0;
   int unsigned ignored_pads = 0;
   int unsigned dropped_tail_pixels = 0;
   int unsigned counted_words = 0;
   int unsigned stall_cycles = 0;
   logic        restart_pending = 1'b0;

   boundary_majority_smoothing DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   // Sizes are saturated to the range the line stores support.
   function automatic int unsigned clamp_dim(input logic [CW-1:0] value,
                                             input int unsigned   hi);
      if (32'(value) < 32'(bms_pkg::MIN_FRAME_SIZE)) return 32'(bms_pkg::MIN_FRAME_SIZE);
      if (32'(value) > hi) return hi;
      return 32'(value);
   endfunction

   // Most frequent neighbor; scanning in up, down, left, right order with a strict
   // greater-than means the earliest of equally frequent values is kept.
   function automatic logic [PW-1:0] neighbor_vote(input logic [3:0][PW-1:0] nb);
      logic [PW-1:0] winner;
      int            top_votes;
      int            votes;
      winner = nb[0];
      top_votes = 0;
      for (int i = 0; i < 4; i++) begin
         votes = 0;
         for (int j = 0; j < 4; j++) begin
            if (nb[i] == nb[j]) votes++;
         end
         if (votes > top_votes) begin
            top_votes = votes;
            winner = nb[i];
         end
      end
      return winner;
   endfunction

   // Advances the predictor by one accepted word and queues the smoothed pixel it releases.
   // The output lags the input by one row plus one pixel, so the window center is the
   // pixel one row up and one column left of the incoming word.
   task automatic smooth_step(input pixel_word_type word);
      int unsigned            w, h, c, r, diff;
      logic                   in_tail;
      logic [PW-1:0]          pix, top, mid, res;
      logic [3:0][PW-1:0]     nb;
      bms_pkg::rsp_entry_type smoothed;
      w = clamp_dim(width_reg, bms_pkg::MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, bms_pkg::MAX_HEIGHT_DEF);
      in_tail = row_pos >= h;
      // A pad while the frame is still arriving carries nothing and moves nothing.
      if (word.pad && !in_tail) begin
         ignored_pads++;
         return;
      end
      if (in_tail && !word.pad) dropped_tail_pixels++;
      pix = in_tail ? '0 : word.pixel;
      c = col_pos;
      r = row_pos;
      top = line_two_above[COL_W'(c)];
      mid = line_above[COL_W'(c)];
      if (r >= 2 || (r == 1 && c >= 1)) begin
         res = win_centre;
         // Only pixels off every border are candidates for replacement.
         if (c >= 2 && c <= w - 1 && r >= 2 && r <= h - 1) begin
            nb = {mid, win_left, win_down, win_up};
            diff = 0;
            for (int k = 0; k < 4; k++) begin
               if (nb[k] != win_centre) diff++;
            end
            if (diff >= 2) res = neighbor_vote(nb);
         end
         emitted++;
         smoothed.pixel = res;
         smoothed.last = (emitted == w * h);
         smoothed_queue.push_back(smoothed);
      end
      win_up = top;
      win_left = win_centre;
      win_centre = mid;
      win_down = pix;
      line_two_above[COL_W'(c)] = mid;
      line_above[COL_W'(c)] = pix;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      col_pos = c;
      row_pos = r;
      if (emitted >= w * h) begin
         col_pos = 0;
         row_pos = 0;
         emitted = 0;
         frames_done++;
      end
   endtask

   // Waits until the driver queue is empty and every expected pixel has come out, then lets
   // the pipeline settle so that words which release nothing have left it too. Checks are
   // made at the falling edge so that they never race the clocked blocks.
   task automatic wait_drained();
      do @(negedge clock); while (word_queue.size() != 0 || smoothed_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the predictor follows once the handshake has completed.
   task automatic write_register(input logic [bms_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [CW-1:0]                 value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      if (idx == bms_pkg::CSR_FRAME_WIDTH) width_reg = value;
      if (idx == bms_pkg::CSR_FRAME_HEIGHT) height_reg = value;
      // A size write restarts the frame; the line stores keep their contents.
      if (idx == bms_pkg::CSR_FRAME_WIDTH || idx == bms_pkg::CSR_FRAME_HEIGHT) begin
         col_pos = 0;
         row_pos = 0;
         emitted = 0;
      end
   endtask

   // Queues a run of frame pixels. Most frames draw from a palette of one to three colors
   // so that majorities and ties are common; some use the full range.
   // About one word in ten is an extra pad that the block must ignore.
   task automatic queue_pixels(input int unsigned count);
      logic [PW-1:0]  palette [3];
      int unsigned    colors;
      pixel_word_type word;
      colors = $urandom_range(3);
      for (int k = 0; k < 3; k++) palette[k] = PW'($urandom);
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0) begin
            word.pad = 1'b1;
            word.pixel = PW'($urandom);
            word_queue.push_back(word);
         end
         word.pad = 1'b0;
         word.pixel = (colors == 0) ? PW'($urandom) : palette[2'($urandom_range(colors - 1))];
         word_queue.push_back(word);
         counted_words++;
      end
   endtask

   // Queues the words that push out the tail of a frame; any pixel given here is dropped.
   task automatic queue_tail(input int unsigned count);
      pixel_word_type word;
      for (int unsigned n = 0; n < count; n++) begin
         word.pad = ($urandom_range(3) != 0);
         word.pixel = PW'($urandom);
         word_queue.push_back(word);
         counted_words++;
      end
   endtask

   task automatic queue_directed_frame(input logic [8:0][PW-1:0] frame,
                                       input logic               mid_pad);
      pixel_word_type word;
      for (int k = 0; k < 9; k++) begin
         if (mid_pad && k == 4) begin
            word.pad = 1'b1;
            word.pixel = 8'hFF;
            word_queue.push_back(word);
         end
         word.pad = 1'b0;
         word.pixel = frame[k];
         word_queue.push_back(word);
         counted_words++;
      end
      queue_tail(4);
   endtask

   // Writes both sizes at the idle block, then queues the start of a frame that the next
   // size write abandons.
   task automatic run_partial_frame(input logic [CW-1:0] wv, input logic [CW-1:0] hv,
                                    input int unsigned count);
      wait_drained();
      write_register(bms_pkg::CSR_FRAME_WIDTH, wv);
      write_register(bms_pkg::CSR_FRAME_HEIGHT, hv);
      queue_pixels(count);
      restart_pending = 1'b1;
   endtask

   // A small random frame. Most frames come with fresh sizes, now and then out of range,
   // a few keep the previous sizes, and some are cut short and then restarted by the next
   // size write.
   task automatic queue_random_frame();
      logic [CW-1:0] wv, hv;
      int unsigned   w, h, pick;
      pick = $urandom_range(15);
      wv = CW'($urandom_range(12, 3));
      hv = CW'($urandom_range(8, 3));
      if (pick == 0) wv = CW'($urandom_range(2));
      if (pick == 1) hv = CW'($urandom_range(2));
      if (restart_pending || $urandom_range(3) != 0) begin
         wait_drained();
         if ($urandom_range(5) == 0) begin
            write_register($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, CW'($urandom));
         end
         if ($urandom_range(1)) begin
            write_register(bms_pkg::CSR_FRAME_WIDTH, wv);
            write_register(bms_pkg::CSR_FRAME_HEIGHT, hv);
         end else begin
            write_register(bms_pkg::CSR_FRAME_HEIGHT, hv);
            write_register(bms_pkg::CSR_FRAME_WIDTH, wv);
         end
      end
      w = clamp_dim(width_reg, bms_pkg::MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, bms_pkg::MAX_HEIGHT_DEF);
      if ($urandom_range(7) == 0) begin
         queue_pixels($urandom_range(w * h - 1, 1));
         restart_pending = 1'b1;
      end else begin
         queue_pixels(w * h);
         queue_tail(w + 1);
         restart_pending = 1'b0;
      end
   endtask

   // Driver: presents the head of the word queue, holds it until taken, and idles at
   // random only between words, never while a word is waiting.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) word_queue.delete(0);
         if (!req_tvalid || req_tready) begin
            if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= word_queue[0].pixel;
               req_tuser <= word_queue[0].pad;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: feeds accepted words to the predictor, checks each result against the oldest
   // expectation, throttles the result side and watches for a hang. All values read here
   // are those from before the edge, since every input is driven with nonblocking writes.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) smooth_step({req_tuser, req_tdata});
         if (rsp_tvalid && rsp_tready) begin
            if (smoothed_queue.size() == 0) begin
               $display("%0t: result with nothing expected: pixel_out %0d frame_last %0b",
                        $time, rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               oldest_smoothed = smoothed_queue.pop_front();
               if (rsp_tdata !== oldest_smoothed.pixel) begin
                  $display("%0t: pixel_out expected %0d actual %0d",
                           $time, oldest_smoothed.pixel, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== oldest_smoothed.last) begin
                  $display("%0t: frame_last expected %0b actual %0b",
                           $time, oldest_smoothed.last, rsp_tlast);
                  failures++;
               end
               results_checked++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
            $display("boundary_majority_smoothing: mismatch");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      pixel_word_type word;
      int unsigned    phase_start;
      // The predictor starts from the reset sizes with a cleared window and position.
      width_reg = CW'(bms_pkg::RESET_FRAME_WIDTH);
      height_reg = CW'(bms_pkg::RESET_FRAME_HEIGHT);
      for (int k = 0; k < bms_pkg::MAX_WIDTH_DEF; k++) begin
         line_above[COL_W'(k)] = '0;
         line_two_above[COL_W'(k)] = '0;
      end
      win_up = '0;
      win_centre = '0;
      win_left = '0;
      win_down = '0;
      col_pos = 0;
      row_pos = 0;
      emitted = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         // Sender 34 / receiver 54, then swapped, then both sides at full rate.
         case (phase)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         if (phase == 0) begin
            // At the reset size of 640 x 480: a pad before any pixel is ignored, and two
            // pixels start a frame that the size write below abandons.
            word.pad = 1'b1;
            word.pixel = 8'h00;
            word_queue.push_back(word);
            word.pad = 1'b0;
            word.pixel = 8'hFF;
            word_queue.push_back(word);
            word.pixel = 8'h00;
            word_queue.push_back(word);
            wait_drained();
            write_register(bms_pkg::CSR_FRAME_WIDTH, CW'(3));
            write_register(bms_pkg::CSR_FRAME_HEIGHT, CW'(3));
            queue_directed_frame(TIE_FRAME, 1'b1);
            queue_directed_frame(DOWN_WINS_FRAME, 1'b0);
            // Size extremes reached through saturation: the widest frame with a height
            // below the minimum, then the narrowest frame at the tallest height. Only the start of
            // each frame is sent before the frame is restarted.
            run_partial_frame(CW'(2047), CW'(2), 16);
            run_partial_frame(CW'(0), CW'(2047), 30);
            // Unused indexes in the middle of a frame; nothing may change.
            wait_drained();
            write_register(CSR_SPARE_HI, CW'(2047));
            write_register(CSR_SPARE_LO, CW'(0));
         end

         phase_start = counted_words;
         while (counted_words - phase_start < RANDOM_WORDS / 3) queue_random_frame();
      end

      wait_drained();
      $display("Checked %0d smoothed pixels over %0d finished frames, %0d register writes.",
               results_checked, frames_done, csr_writes);
      $display("The block ignored %0d in-frame pads and dropped %0d pixels sent in tails.",
               ignored_pads, dropped_tail_pixels);
      if (failures == 0 && smoothed_queue.size() == 0) begin
         $display("boundary_majority_smoothing: match");
      end else begin
         $display("boundary_majority_smoothing: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/bms_pkg.sv
rtl/bms_ram.sv
rtl/boundary_majority_smoothing.sv
rtl/bms_chk.sv
dv/tb_top.sv
